// ===== rtl/core/rse_pkg.sv =====
// Shared types and constants for the randomized set engine.
// No dependencies; imported by rse_mod, the core and the testbench.
`default_nettype none
package rse_pkg;

  localparam int DRAW_W  = 15;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_RANDOM = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE          = 2'd0,
    ST_DUP_OR_ABSENT = 2'd1,
    ST_FULL          = 2'd2,
    ST_EMPTY         = 2'd3
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic [DRAW_W-1:0]         random_draw;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] element;
    logic [COUNT_W-1:0]        element_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WR_LAST,
    S_MOD,
    S_ELEM,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/rse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/rse_mod.sv =====
// Bit-serial restoring remainder: draw mod divisor, one dividend bit a cycle.
// Depends on rse_pkg for the draw width.
`default_nettype none
module rse_mod #(
  parameter int CW = 7
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rse_pkg::DRAW_W-1:0] dividend,
  input  wire logic [CW-1:0]             divisor,
  output logic                           done,
  output logic [CW-1:0]                  rem
);
  import rse_pkg::*;

  localparam int NW = $clog2(DRAW_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic [DRAW_W-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0]     div_r, div_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [CW:0]       trial;
  logic [CW:0]       trial_sub;

  assign trial     = {rem_r, dvd_r[DRAW_W-1]};
  assign trial_sub = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so CW bits hold it
      rem_nxt = (trial >= {1'b0, div_r}) ? trial_sub[CW-1:0] : trial[CW-1:0];
      dvd_nxt = {dvd_r[DRAW_W-2:0], 1'b0};
      cnt_nxt = cnt_r + NW'(1);
      if (cnt_r == NW'(DRAW_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ===== rtl/core/randomized_set_engine_core.sv =====
// Randomized set engine: insert, remove and get-random over a dense store.
// Depends on rse_pkg, rse_ram and rse_mod.
//
// Input channel in_valid/in_ready/in_data carries op, value and random_draw;
// result channel out_valid/out_ready/out_data carries status, element and
// element_count. Exactly one result per accepted item, in order.
// in_ready is high only while the sequencer is idle; one item at a time.
// Insert and remove scan the occupied entries through the RAM read port,
// one entry per cycle, pipelined against the registered read data; remove
// then moves the last entry into the freed slot in S_WR_LAST, and the
// result is loaded from S_RESP. Get-random runs the 15-bit draw through
// the serial remainder unit, then one RAM read fetches the element.
// The result sits in an output register, so the next item is accepted
// while an earlier result still waits; a result that cannot be loaded
// because the receiver stalls holds the sequencer until the register frees.
// Reset (rst_n low, synchronous) empties the set; stored entries are not
// cleared, as only entries below the count are ever read.
`default_nettype none
module randomized_set_engine_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rse_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rse_pkg::out_item_t      out_data
);
  import rse_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [VALUE_W-1:0]    value_r, value_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         scan_addr_r, scan_addr_nxt;
  logic                  cmp_valid_r, cmp_valid_nxt;
  logic [AW-1:0]         cmp_addr_r, cmp_addr_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  status_t               status_r, status_nxt;
  logic [VALUE_W-1:0]    elem_r, elem_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_W-1:0]    ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_W-1:0]    ram_rdata;

  logic                  mod_start;
  logic                  mod_done;
  logic [CW-1:0]         mod_rem;

  logic                  in_xfer;
  logic                  hit;
  logic                  scan_more;
  logic                  miss;
  logic                  is_full;
  logic                  out_free;
  logic [CW-1:0]         last_idx;
  logic [CW-1:0]         rem_idx;
  logic [CW+COUNT_W-1:0] count_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign hit       = cmp_valid_r && (ram_rdata == value_r);
  assign scan_more = (scan_addr_r < count_r);
  assign miss      = !cmp_valid_r && !scan_more;
  assign is_full   = (count_r >= CW'(CAPACITY));
  assign out_free  = !out_valid_r || out_ready;
  assign last_idx  = count_r - CW'(1);
  assign rem_idx   = mod_rem;
  assign count_ext = {{COUNT_W{1'b0}}, count_r};

  rse_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rse_mod #(
    .CW (CW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_data.random_draw),
    .divisor  (count_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          priority if (in_data.op == OP_INSERT || in_data.op == OP_REMOVE) begin
            state_nxt = S_SCAN;
          end else if (in_data.op == OP_RANDOM && count_r != '0) begin
            state_nxt = S_MOD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = (op_r == OP_REMOVE) ? S_WR_LAST : S_RESP;
        end else if (miss) begin
          state_nxt = S_RESP;
        end
      end
      S_WR_LAST: state_nxt = S_RESP;
      S_MOD:     if (mod_done) state_nxt = S_ELEM;
      S_ELEM:    state_nxt = S_RESP;
      S_RESP:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    op_nxt        = op_r;
    value_nxt     = value_r;
    count_nxt     = count_r;
    scan_addr_nxt = scan_addr_r;
    cmp_valid_nxt = 1'b0;
    cmp_addr_nxt  = cmp_addr_r;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    elem_nxt      = elem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = value_r;
    ram_raddr     = scan_addr_r[AW-1:0];
    mod_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt        = in_data.op;
          value_nxt     = in_data.value;
          scan_addr_nxt = '0;
          status_nxt    = ST_DONE;
          elem_nxt      = '0;
          if (in_data.op == OP_RANDOM) begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              mod_start = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          slot_nxt = cmp_addr_r;
          if (op_r == OP_REMOVE) begin
            ram_raddr = last_idx[AW-1:0];
          end else begin
            status_nxt = ST_DUP_OR_ABSENT;
          end
        end else if (miss) begin
          if (op_r == OP_REMOVE) begin
            status_nxt = ST_DUP_OR_ABSENT;
          end else if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end else if (scan_more) begin
          // issue next read; its data is compared next cycle
          cmp_valid_nxt = 1'b1;
          cmp_addr_nxt  = scan_addr_r[AW-1:0];
          scan_addr_nxt = scan_addr_r + CW'(1);
        end
      end
      S_WR_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = ram_rdata;
        count_nxt = last_idx;
      end
      S_MOD: begin
        ram_raddr = rem_idx[AW-1:0];
      end
      S_ELEM: begin
        elem_nxt = ram_rdata;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.element       = elem_r;
          out_data_nxt.element_count = count_ext[COUNT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    value_r     <= value_nxt;
    scan_addr_r <= scan_addr_nxt;
    cmp_addr_r  <= cmp_addr_nxt;
    slot_r      <= slot_nxt;
    status_r    <= status_nxt;
    elem_r      <= elem_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== tb/tb_randomized_set_engine_core.sv =====
// Self-checking testbench for randomized_set_engine_core: insert, remove and
// get-random on a 64-entry set, checked against a set model held in the bench.
// Depends on rse_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 1ps
module tb_randomized_set_engine_core;
  import rse_pkg::*;

  localparam int SET_CAPACITY   = 64;
  localparam int RANDOM_ITEMS   = 1880;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int PRINT_CAP      = 40;

  typedef enum int { EP_GROW, EP_SHRINK, EP_MIXED } episode_t;

  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t result;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // expected value typed into the directed table, travels with in_data
  bit        pin_flag;
  out_item_t pin_result;
  bit        calm;

  logic [VALUE_W-1:0] set_store [SET_CAPACITY];
  int                 set_count;
  out_item_t          pending_results [$];

  int mismatches, in_transfers, out_transfers, full_hits, empty_hits, idle_cycles;

  dir_row_t dir_rows [0:21] = '{
    '{'{OP_RANDOM, 32'sh00000000, 15'h0000}, 1'b1, '{ST_EMPTY,         32'sh0,        7'd0}},
    '{'{OP_REMOVE, 32'sh00000000, 15'h0000}, 1'b1, '{ST_DUP_OR_ABSENT, 32'sh0,        7'd0}},
    '{'{OP_NONE,   32'shFFFFFFFF, 15'h7FFF}, 1'b1, '{ST_DONE,          32'sh0,        7'd0}},
    '{'{OP_INSERT, 32'sh80000000, 15'h7FFF}, 1'b1, '{ST_DONE,          32'sh0,        7'd1}},
    '{'{OP_INSERT, 32'sh7FFFFFFF, 15'h0000}, 1'b1, '{ST_DONE,          32'sh0,        7'd2}},
    '{'{OP_INSERT, 32'sh00000000, 15'h0000}, 1'b1, '{ST_DONE,          32'sh0,        7'd3}},
    '{'{OP_INSERT, 32'shFFFFFFFF, 15'h0000}, 1'b1, '{ST_DONE,          32'sh0,        7'd4}},
    '{'{OP_INSERT, 32'sh80000000, 15'h0000}, 1'b1, '{ST_DUP_OR_ABSENT, 32'sh0,        7'd4}},
    '{'{OP_RANDOM, 32'sh00000000, 15'h0000}, 1'b1, '{ST_DONE,          32'sh80000000, 7'd4}},
    '{'{OP_RANDOM, 32'sh55555555, 15'h7FFF}, 1'b0, '0},
    '{'{OP_RANDOM, 32'sh00000000, 15'h0001}, 1'b1, '{ST_DONE,          32'sh7FFFFFFF, 7'd4}},
    '{'{OP_REMOVE, 32'sh80000000, 15'h0000}, 1'b1, '{ST_DONE,          32'sh0,        7'd3}},
    '{'{OP_RANDOM, 32'sh00000000, 15'h0000}, 1'b0, '0},
    '{'{OP_REMOVE, 32'sh00012345, 15'h0000}, 1'b1, '{ST_DUP_OR_ABSENT, 32'sh0,        7'd3}},
    '{'{OP_NONE,   32'sh2AAAAAAA, 15'h2AAA}, 1'b1, '{ST_DONE,          32'sh0,        7'd3}},
    '{'{OP_REMOVE, 32'shFFFFFFFF, 15'h0000}, 1'b0, '0},
    '{'{OP_REMOVE, 32'sh7FFFFFFF, 15'h0000}, 1'b0, '0},
    '{'{OP_REMOVE, 32'sh00000000, 15'h0000}, 1'b0, '0},
    '{'{OP_RANDOM, 32'sh00000000, 15'h7FFF}, 1'b1, '{ST_EMPTY,         32'sh0,        7'd0}},
    '{'{OP_INSERT, 32'sh55555555, 15'h2AAA}, 1'b0, '0},
    '{'{OP_RANDOM, 32'sh00000000, 15'h5555}, 1'b0, '0},
    '{'{OP_INSERT, 32'sh2AAAAAAA, 15'h0000}, 1'b0, '0}
  };

  randomized_set_engine_core #(.CAPACITY(SET_CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Set model: search, append, move-last-into-hole, draw mod count.
  function automatic out_item_t apply_set_op(in_item_t it);
    out_item_t r;
    int        slot;
    r.status        = ST_DONE;
    r.element       = '0;
    slot            = -1;
    for (int i = 0; i < set_count; i++) begin
      if (slot < 0 && set_store[i] == it.value) slot = i;
    end
    case (it.op)
      OP_INSERT: begin
        if (slot >= 0) r.status = ST_DUP_OR_ABSENT;
        else if (set_count >= SET_CAPACITY) r.status = ST_FULL;
        else begin
          set_store[set_count] = it.value;
          set_count++;
        end
      end
      OP_REMOVE: begin
        if (slot < 0) r.status = ST_DUP_OR_ABSENT;
        else begin
          set_store[slot] = set_store[set_count-1];
          set_count--;
        end
      end
      OP_RANDOM: begin
        if (set_count == 0) r.status = ST_EMPTY;
        else r.element = set_store[int'(it.random_draw) % set_count];
      end
      default: ;
    endcase
    r.element_count = set_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t ERROR: %s", $time, msg);
  endtask

  function automatic int pick_gap(bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic in_item_t make_item(episode_t kind);
    in_item_t it;
    int       r;
    int       pick;
    r              = $urandom_range(0, 99);
    it.value       = $urandom;
    it.random_draw = DRAW_W'($urandom_range(0, 32767));
    case (kind)
      EP_GROW:   it.op = (r < 72) ? OP_INSERT : (r < 82) ? OP_REMOVE :
                         (r < 97) ? OP_RANDOM : OP_NONE;
      EP_SHRINK: it.op = (r < 10) ? OP_INSERT : (r < 80) ? OP_REMOVE :
                         (r < 97) ? OP_RANDOM : OP_NONE;
      default:   it.op = (r < 40) ? OP_INSERT : (r < 75) ? OP_REMOVE :
                         (r < 96) ? OP_RANDOM : OP_NONE;
    endcase
    pick = $urandom_range(0, 99);
    if (it.op == OP_INSERT || it.op == OP_REMOVE) begin
      if (set_count > 0 && pick < ((it.op == OP_INSERT) ? 20 : 70))
        it.value = set_store[$urandom_range(0, set_count-1)];
      else if (pick < 80)
        it.value = $urandom_range(0, 127);
      else if (pick < 88)
        case ($urandom_range(0, 3))
          0: it.value = 32'sh80000000;
          1: it.value = 32'sh7FFFFFFF;
          2: it.value = 32'sh00000000;
          default: it.value = 32'shFFFFFFFF;
        endcase
    end else if (pick < 15) begin
      it.random_draw = DRAW_W'($urandom_range(0, 200));
    end else if (pick < 25) begin
      it.random_draw = (pick < 20) ? 15'h0000 : 15'h7FFF;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit pinned, input out_item_t res,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= it;
    pin_flag   <= pinned;
    pin_result <= res;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // receiver: ready runs broken by stalls, none while calm
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int run;
      int gap;
      run = $urandom_range(1, 20);
      gap = pick_gap(1'b0);
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
      if (!calm) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // scoreboard and watchdog, sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      bit        moved;
      out_item_t want;
      out_item_t got;
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        out_transfers++;
        got = out_data;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing outstanding: %p", got));
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      got.status, want.status));
          if (got.element !== want.element)
            report_mismatch($sformatf("element got %h want %h",
                                      got.element, want.element));
          if (got.element_count !== want.element_count)
            report_mismatch($sformatf("element_count got %0d want %0d",
                                      got.element_count, want.element_count));
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        in_transfers++;
        want = apply_set_op(in_data);
        if (want.status == ST_FULL) full_hits++;
        if (want.status == ST_EMPTY) empty_hits++;
        if (pin_flag) want = pin_result;
        pending_results = {pending_results, want};
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
        $display("tb_randomized_set_engine_core: FAIL");
        $finish;
      end
    end
  end

  initial begin
    episode_t kind;
    int       ep_len;
    int       sent;
    int       ep_no;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    pin_flag   = 1'b0;
    pin_result = '0;
    calm       = 1'b0;
    set_count  = 0;
    mismatches = 0;
    in_transfers = 0;
    out_transfers = 0;
    full_hits  = 0;
    empty_hits = 0;
    idle_cycles = 0;
    for (int i = 0; i < SET_CAPACITY; i++) set_store[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].result, pick_gap(1'b1));
    drain_pause();

    // well-formed episodes: one weighted to fill the set, one to drain it, then a mix
    sent  = 0;
    ep_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (ep_no == 0) kind = EP_GROW;
      else if (ep_no == 1) kind = EP_SHRINK;
      else kind = episode_t'($urandom_range(0, 2));
      ep_len = (ep_no < 2) ? 150 : $urandom_range(30, 150);
      calm   = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ep_len && sent < RANDOM_ITEMS; k++) begin
        send_item(make_item(kind), 1'b0, '0, calm ? 0 : pick_gap(1'b1));
        sent++;
      end
      if ($urandom_range(0, 9) < 3) drain_pause();
      ep_no++;
    end

    in_valid <= 1'b0;
    calm     = 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d operations in and %0d results out over %0d episodes",
             in_transfers, out_transfers, ep_no);
    $display("store full hit %0d times, get-random on empty set %0d times",
             full_hits, empty_hits);
    if (mismatches == 0) begin
      $display("tb_randomized_set_engine_core: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_randomized_set_engine_core: FAIL");
    end
    $finish;
  end

endmodule
